// ----- hw/rtl/prs_pkg.sv -----
// Shared types and constants for the page replacement simulator.
// No dependencies.
`default_nettype none
package prs_pkg;
	localparam int unsigned IDX_W   = 5;
	localparam int unsigned NFR_W   = 6;
	localparam int unsigned PAGE_W  = 8;
	localparam int unsigned STAMP_W = 7;
	localparam int unsigned POS_W   = 7;
	localparam int unsigned KEY_W   = 8;

	localparam logic [1:0] MODE_LRU = 2'd1;
	localparam logic [1:0] MODE_OPT = 2'd2;

	localparam logic CFG_MODE = 1'b0;
	localparam logic CFG_NFR  = 1'b1;

	typedef struct packed {
		logic               clr;
		logic               load;
		logic               touch;
		logic [PAGE_W-1:0]  page;
		logic [STAMP_W-1:0] stamp;
		logic               scan_clr;
		logic               scan_valid;
		logic [PAGE_W-1:0]  scan_page;
		logic [POS_W-1:0]   scan_idx;
		logic               use_next;
	} cell_ctrl_t;

	typedef struct packed {
		logic              hit_found;
		logic [IDX_W-1:0]  hit_idx;
		logic              emp_found;
		logic [IDX_W-1:0]  emp_idx;
		logic [KEY_W-1:0]  vic_key;
		logic [IDX_W-1:0]  vic_idx;
		logic [PAGE_W-1:0] vic_page;
	} carry_t;
endpackage
`default_nettype wire

// ----- hw/rtl/prs_ram.sv -----
// Generic single write, single read RAM with registered read data.
// No dependencies.
`default_nettype none
module prs_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ----- hw/rtl/prs_cell.sv -----
// One frame cell: page, valid, stamp and next use; passes a registered
// search carry to its neighbour. Depends on prs_pkg.
`default_nettype none
module prs_cell #(
	parameter int unsigned IDX = 0
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire prs_pkg::cell_ctrl_t ctrl,
	input  wire logic                sel,
	input  wire logic                part,
	input  wire prs_pkg::carry_t     cin,
	output prs_pkg::carry_t          cout
);
	logic [prs_pkg::PAGE_W-1:0]  page_q;
	logic                        valid_q;
	logic [prs_pkg::STAMP_W-1:0] stamp_q;
	logic                        nf_q;
	logic [prs_pkg::POS_W-1:0]   nxt_q;
	logic [prs_pkg::KEY_W-1:0]   key;
	prs_pkg::carry_t             c;

	always_comb begin
		if (ctrl.use_next) begin
			key = nf_q ? (prs_pkg::KEY_W'(127) - {1'b0, nxt_q}) : '0;
		end else begin
			key = {1'b0, stamp_q};
		end
		c = cin;
		if (part) begin
			if (!cin.hit_found && valid_q && page_q == ctrl.page) begin
				c.hit_found = 1'b1;
				c.hit_idx   = prs_pkg::IDX_W'(IDX);
			end
			if (!cin.emp_found && !valid_q) begin
				c.emp_found = 1'b1;
				c.emp_idx   = prs_pkg::IDX_W'(IDX);
			end
			if (key < cin.vic_key) begin
				c.vic_key  = key;
				c.vic_idx  = prs_pkg::IDX_W'(IDX);
				c.vic_page = page_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			page_q  <= '0;
			stamp_q <= '0;
			nf_q    <= 1'b0;
			nxt_q   <= '0;
			cout    <= '0;
		end else begin
			cout <= c;
			if (ctrl.clr) begin
				valid_q <= 1'b0;
				page_q  <= '0;
				stamp_q <= '0;
			end else if (sel) begin
				if (ctrl.load) begin
					valid_q <= 1'b1;
					page_q  <= ctrl.page;
				end
				if (ctrl.load || ctrl.touch) begin
					stamp_q <= ctrl.stamp;
				end
			end
			if (ctrl.scan_clr) begin
				nf_q <= 1'b0;
			end else if (ctrl.scan_valid && !nf_q && ctrl.scan_page == page_q) begin
				nf_q  <= 1'b1;
				nxt_q <= ctrl.scan_idx;
			end
		end
	end
endmodule
`default_nettype wire

// ----- hw/rtl/page_replacement_simulator_unit.sv -----
// Page replacement simulator top level: sequencer, request store, frame cells.
// Depends on prs_pkg, prs_ram, prs_cell.
//
// Requests arrive on page/last with in_valid/in_stall. Each request without
// last is accepted in idle and gives no result. A request with last starts a
// replay: in_stall stays high until every stored request has given its item
// on the output channel (out_valid/out_stall), in order.
// Per result item: one store read, a search through the row of frame cells,
// a decide step and the output register. Under the optimal policy a
// full-frame miss adds a scan with one store read per later stored request,
// a step to close the scan and a second cell search.
// An item is held in the output register while out_stall is high and the
// sequencer waits. Configuration (cfg_valid/cfg_ready, always ready) is
// to be written by the user between runs; the block does not enforce it. Reset
// clears all frames and the stored count; mode returns to FIFO and the frame
// count setting to 4.
`default_nettype none
module page_replacement_simulator_unit #(
	parameter int unsigned MAX_FRAMES = 16,
	parameter int unsigned SEQ_DEPTH  = 64
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic       cfg_index,
	input  wire logic [4:0] cfg_data,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] page,
	input  wire logic       last,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [5:0]      req_index,
	output logic [7:0]      req_page,
	output logic            hit,
	output logic [3:0]      frame,
	output logic            evicted_valid,
	output logic [7:0]      evicted_page,
	output logic [6:0]      miss_count,
	output logic            run_end
);
	localparam int unsigned AW = (SEQ_DEPTH > 1) ? $clog2(SEQ_DEPTH) : 1;
	localparam int unsigned CW = $clog2(SEQ_DEPTH + 1);
	localparam int unsigned WW = $clog2(MAX_FRAMES + 2);

	typedef enum logic [3:0] {
		ST_IDLE, ST_RD, ST_LATCH, ST_CHAIN, ST_DECIDE,
		ST_SCAN, ST_SCAN_END, ST_CHAIN2, ST_OUT
	} state_t;

	state_t                        state_q;
	logic [1:0]                    mode_q;
	logic [4:0]                    nfr_cfg_q;
	logic [prs_pkg::NFR_W-1:0]     n_q;
	logic [CW-1:0]                 cnt_q, count_q, k_q, j_q;
	logic [WW-1:0]                 wait_q;
	logic [7:0]                    p_q;
	logic [prs_pkg::STAMP_W-1:0]   stamp_q;
	logic [6:0]                    misses_q;
	logic                          clr_q, load_q, touch_q, scan_clr_q, use_next_q;
	logic [prs_pkg::IDX_W-1:0]     sel_q;
	logic [prs_pkg::STAMP_W-1:0]   cst_q;
	logic                          sv_s1;
	logic [CW-1:0]                 sj_s1;
	logic                          in_acc, store_we;
	logic [AW-1:0]                 raddr;
	logic [7:0]                    rdata;
	logic [prs_pkg::NFR_W-1:0]     n_next;
	prs_pkg::cell_ctrl_t           ctrl;
	prs_pkg::carry_t               carry [MAX_FRAMES+1];
	prs_pkg::carry_t               tail;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign store_we  = in_acc && (cnt_q < CW'(SEQ_DEPTH));
	assign tail      = carry[MAX_FRAMES];

	always_comb begin
		case (state_q)
			ST_SCAN: raddr = j_q[AW-1:0];
			default: raddr = k_q[AW-1:0];
		endcase
		if (nfr_cfg_q == 5'd0) begin
			n_next = prs_pkg::NFR_W'(1);
		end else if ({1'b0, nfr_cfg_q} > prs_pkg::NFR_W'(MAX_FRAMES)) begin
			n_next = prs_pkg::NFR_W'(MAX_FRAMES);
		end else begin
			n_next = {1'b0, nfr_cfg_q};
		end
		ctrl.clr        = clr_q;
		ctrl.load       = load_q;
		ctrl.touch      = touch_q;
		ctrl.page       = p_q;
		ctrl.stamp      = cst_q;
		ctrl.scan_clr   = scan_clr_q;
		ctrl.scan_valid = sv_s1;
		ctrl.scan_page  = rdata;
		ctrl.scan_idx   = prs_pkg::POS_W'(sj_s1);
		ctrl.use_next   = use_next_q;
	end

	prs_ram #(.WIDTH(8), .DEPTH(SEQ_DEPTH)) u_store (
		.clk   (clk),
		.we    (store_we),
		.waddr (cnt_q[AW-1:0]),
		.wdata (page),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		carry[0]         = '0;
		carry[0].vic_key = '1;
	end

	for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
		prs_cell #(.IDX(i)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.sel    (sel_q == prs_pkg::IDX_W'(i)),
			.part   (prs_pkg::NFR_W'(i) < n_q),
			.cin    (carry[i]),
			.cout   (carry[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			mode_q        <= 2'd0;
			nfr_cfg_q     <= 5'd4;
			n_q           <= '0;
			cnt_q         <= '0;
			count_q       <= '0;
			k_q           <= '0;
			j_q           <= '0;
			wait_q        <= '0;
			p_q           <= '0;
			stamp_q       <= '0;
			misses_q      <= '0;
			clr_q         <= 1'b0;
			load_q        <= 1'b0;
			touch_q       <= 1'b0;
			scan_clr_q    <= 1'b0;
			use_next_q    <= 1'b0;
			sel_q         <= '0;
			cst_q         <= '0;
			sv_s1         <= 1'b0;
			sj_s1         <= '0;
			out_valid     <= 1'b0;
			req_index     <= '0;
			req_page      <= '0;
			hit           <= 1'b0;
			frame         <= '0;
			evicted_valid <= 1'b0;
			evicted_page  <= '0;
			miss_count    <= '0;
			run_end       <= 1'b0;
		end else begin
			clr_q      <= 1'b0;
			load_q     <= 1'b0;
			touch_q    <= 1'b0;
			scan_clr_q <= 1'b0;
			sv_s1      <= (state_q == ST_SCAN);
			sj_s1      <= j_q;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					prs_pkg::CFG_MODE: mode_q <= cfg_data[1:0];
					prs_pkg::CFG_NFR:  nfr_cfg_q <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (store_we) begin
							cnt_q <= cnt_q + CW'(1);
						end
						if (last) begin
							count_q  <= store_we ? cnt_q + CW'(1) : cnt_q;
							n_q      <= n_next;
							k_q      <= '0;
							clr_q    <= 1'b1;
							stamp_q  <= '0;
							misses_q <= '0;
							state_q  <= ST_RD;
						end
					end
				end
				ST_RD: begin
					state_q <= ST_LATCH;
				end
				ST_LATCH: begin
					p_q        <= rdata;
					use_next_q <= 1'b0;
					wait_q     <= '0;
					state_q    <= ST_CHAIN;
				end
				ST_CHAIN: begin
					wait_q <= wait_q + WW'(1);
					if (wait_q == WW'(MAX_FRAMES)) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					req_index     <= 6'(k_q);
					req_page      <= p_q;
					run_end       <= (k_q + CW'(1) == count_q);
					evicted_valid <= 1'b0;
					evicted_page  <= '0;
					if (tail.hit_found) begin
						hit        <= 1'b1;
						frame      <= 4'(tail.hit_idx);
						miss_count <= misses_q;
						if (mode_q == prs_pkg::MODE_LRU) begin
							touch_q <= 1'b1;
							sel_q   <= tail.hit_idx;
							cst_q   <= stamp_q + prs_pkg::STAMP_W'(1);
							stamp_q <= stamp_q + prs_pkg::STAMP_W'(1);
						end
						out_valid <= 1'b1;
						state_q   <= ST_OUT;
					end else if (tail.emp_found) begin
						hit        <= 1'b0;
						frame      <= 4'(tail.emp_idx);
						misses_q   <= misses_q + 7'd1;
						miss_count <= misses_q + 7'd1;
						load_q     <= 1'b1;
						sel_q      <= tail.emp_idx;
						cst_q      <= stamp_q + prs_pkg::STAMP_W'(1);
						stamp_q    <= stamp_q + prs_pkg::STAMP_W'(1);
						out_valid  <= 1'b1;
						state_q    <= ST_OUT;
					end else if (mode_q == prs_pkg::MODE_OPT) begin
						scan_clr_q <= 1'b1;
						j_q        <= k_q + CW'(1);
						wait_q     <= '0;
						if (k_q + CW'(1) < count_q) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_SCAN_END;
						end
					end else begin
						hit           <= 1'b0;
						frame         <= 4'(tail.vic_idx);
						evicted_valid <= 1'b1;
						evicted_page  <= tail.vic_page;
						misses_q      <= misses_q + 7'd1;
						miss_count    <= misses_q + 7'd1;
						load_q        <= 1'b1;
						sel_q         <= tail.vic_idx;
						cst_q         <= stamp_q + prs_pkg::STAMP_W'(1);
						stamp_q       <= stamp_q + prs_pkg::STAMP_W'(1);
						out_valid     <= 1'b1;
						state_q       <= ST_OUT;
					end
				end
				ST_SCAN: begin
					j_q <= j_q + CW'(1);
					if (j_q + CW'(1) == count_q) begin
						state_q <= ST_SCAN_END;
					end
				end
				ST_SCAN_END: begin
					use_next_q <= 1'b1;
					wait_q     <= '0;
					state_q    <= ST_CHAIN2;
				end
				ST_CHAIN2: begin
					wait_q <= wait_q + WW'(1);
					if (wait_q == WW'(MAX_FRAMES)) begin
						hit           <= 1'b0;
						frame         <= 4'(tail.vic_idx);
						evicted_valid <= 1'b1;
						evicted_page  <= tail.vic_page;
						misses_q      <= misses_q + 7'd1;
						miss_count    <= misses_q + 7'd1;
						load_q        <= 1'b1;
						sel_q         <= tail.vic_idx;
						cst_q         <= stamp_q + prs_pkg::STAMP_W'(1);
						stamp_q       <= stamp_q + prs_pkg::STAMP_W'(1);
						out_valid     <= 1'b1;
						state_q       <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!out_stall) begin
						out_valid <= 1'b0;
						if (k_q + CW'(1) == count_q) begin
							cnt_q   <= '0;
							state_q <= ST_IDLE;
						end else begin
							k_q     <= k_q + CW'(1);
							state_q <= ST_RD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_no_input_in_replay: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input accepted while a result is pending");
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && hit) |-> !evicted_valid)
		else $error("hit reported with an eviction");
	a_evp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !evicted_valid) |-> (evicted_page == 8'd0))
		else $error("evicted page set without eviction");
	a_miss_bump: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !hit) |-> (miss_count != 7'd0))
		else $error("miss with zero miss count");
endmodule
`default_nettype wire

// ----- tb/prs_checker.sv -----
// Checker for the page replacement simulator: watches the request, result and
// register channels, predicts each replay and compares every result item.
// Depends on prs_pkg.
`timescale 1ns / 1ps
module prs_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	input  logic       cfg_ready,
	input  logic       cfg_index,
	input  logic [4:0] cfg_data,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [7:0] page,
	input  logic       last,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [5:0] req_index,
	input  logic [7:0] req_page,
	input  logic       hit,
	input  logic [3:0] frame,
	input  logic       evicted_valid,
	input  logic [7:0] evicted_page,
	input  logic [6:0] miss_count,
	input  logic       run_end,
	output int         fail_count,
	output int         pending,
	output int         results_seen
);
	typedef struct packed {
		logic [5:0] idx;
		logic [7:0] pg;
		logic       h;
		logic [3:0] fr;
		logic       ev;
		logic [7:0] evp;
		logic [6:0] mc;
		logic       fin;
	} replay_res_t;

	replay_res_t expected_q[$];
	logic [7:0]  seq_pages[64];
	int          seq_len;
	logic [1:0]  pol;
	logic [4:0]  nfr_reg;

	assign pending = expected_q.size();

	task automatic replay_sequence();
		logic [7:0]  fpage[16];
		logic        fval[16];
		logic [6:0]  fstamp[16];
		logic [6:0]  ctr, misses;
		int          n, f, i, j, nxt[16];
		logic        h, ev, found, done;
		logic [7:0]  evp, p;
		replay_res_t r;
		n = (nfr_reg == 0) ? 1 : (nfr_reg > 16 ? 16 : nfr_reg);
		ctr = 7'd0;
		misses = 7'd0;
		for (i = 0; i < 16; i++) begin
			fpage[i] = 8'd0; fval[i] = 1'b0; fstamp[i] = 7'd0;
		end
		for (int k = 0; k < seq_len; k++) begin
			p = seq_pages[k];
			h = 0; ev = 0; evp = 0; f = 0;
			for (i = 0; i < n && !h; i++)
				if (fval[i] && fpage[i] == p) begin
					h = 1; f = i;
				end
			if (h) begin
				if (pol == prs_pkg::MODE_LRU) begin
					ctr = ctr + 7'd1; fstamp[f] = ctr;
				end
			end else begin
				misses = misses + 7'd1;
				found = 0;
				for (i = 0; i < n && !found; i++)
					if (!fval[i]) begin
						found = 1; f = i;
					end
				if (!found) begin
					if (pol == prs_pkg::MODE_OPT) begin
						done = 0;
						for (i = 0; i < n && !done; i++) begin
							nxt[i] = -1;
							for (j = k + 1; j < seq_len && nxt[i] < 0; j++)
								if (seq_pages[j] == fpage[i]) nxt[i] = j;
							if (nxt[i] < 0) begin
								f = i; done = 1;
							end
						end
						if (!done) begin
							f = 0;
							for (i = 1; i < n; i++) if (nxt[i] > nxt[f]) f = i;
						end
					end else begin
						f = 0;
						for (i = 1; i < n; i++) if (fstamp[i] < fstamp[f]) f = i;
					end
					ev = 1; evp = fpage[f];
				end
				fval[f] = 1; fpage[f] = p;
				ctr = ctr + 7'd1; fstamp[f] = ctr;
			end
			r = '{idx: k[5:0], pg: p, h: h, fr: f[3:0], ev: ev, evp: evp,
				mc: misses, fin: (k + 1 == seq_len)};
			expected_q.push_back(r);
		end
		seq_len = 0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		replay_res_t e;
		if (!arst_n) begin
			pol <= 2'd0;
			nfr_reg <= 5'd4;
			seq_len = 0;
			fail_count <= 0;
			results_seen <= 0;
			expected_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == prs_pkg::CFG_MODE) pol <= cfg_data[1:0];
				else nfr_reg <= cfg_data;
			end
			if (in_valid && !in_stall) begin
				if (seq_len < 64) begin
					seq_pages[seq_len] = page;
					seq_len++;
				end
				if (last) replay_sequence();
			end
			if (out_valid && !out_stall) begin
				results_seen <= results_seen + 1;
				if (expected_q.size() == 0) begin
					$error("result item with nothing expected");
					fail_count <= fail_count + 1;
				end else begin
					e = expected_q.pop_front();
					if ({req_index, req_page, hit, frame, evicted_valid, evicted_page,
						miss_count, run_end} !== e) begin
						fail_count <= fail_count + 1;
						if (req_index !== e.idx)
							$error("req_index: expected %0d, got %0d", e.idx, req_index);
						if (req_page !== e.pg)
							$error("req_page: expected %0d, got %0d", e.pg, req_page);
						if (hit !== e.h) $error("hit: expected %0d, got %0d", e.h, hit);
						if (frame !== e.fr) $error("frame: expected %0d, got %0d", e.fr, frame);
						if (evicted_valid !== e.ev)
							$error("evicted_valid: expected %0d, got %0d", e.ev, evicted_valid);
						if (evicted_page !== e.evp)
							$error("evicted_page: expected %0d, got %0d", e.evp, evicted_page);
						if (miss_count !== e.mc)
							$error("miss_count: expected %0d, got %0d", e.mc, miss_count);
						if (run_end !== e.fin)
							$error("run_end: expected %0d, got %0d", e.fin, run_end);
					end
				end
			end
		end
	end
endmodule

// ----- tb/testbench.sv -----
// Top of the page replacement simulator testbench: clock, reset, request and
// register stimulus, verdict. Depends on prs_pkg, prs_checker and the block.
`timescale 1ns / 1ps
module testbench;
	logic       clk = 0;
	logic       arst_n = 0;
	logic       cfg_valid = 0, cfg_index = 0;
	logic [4:0] cfg_data = 0;
	logic       cfg_ready;
	logic       in_valid = 0, in_stall;
	logic [7:0] page = 0;
	logic       last = 0;
	logic       out_valid, out_stall = 0;
	logic [5:0] req_index;
	logic [7:0] req_page, evicted_page;
	logic       hit, evicted_valid, run_end;
	logic [3:0] frame;
	logic [6:0] miss_count;
	int         fail_count, pending, results_seen;
	int         send_idle = 0, recv_idle = 0, requests_sent = 0, idle_cycles = 0;

	always #1 clk = ~clk;

	page_replacement_simulator_unit dut (.*);
	prs_checker checker_i (.*);

	always @(negedge clk) out_stall <= ($urandom_range(99) < recv_idle);

	// watchdog: cycles with nothing accepted
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_valid)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 200000) begin
			$display("** page_replacement_simulator_unit: FAILED **");
			$finish;
		end
	end

	task automatic write_reg(input logic idx, input logic [4:0] val);
		@(negedge clk);
		cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	// in_valid stays high into the next request; an idle or drain drops it
	task automatic send_request(input logic [7:0] pg, input logic lst);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1; page <= pg; last <= lst;
		do @(posedge clk); while (in_stall);
		requests_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (300) @(negedge clk);
	endtask

	// sequence over a small page pool so hits and evictions are common
	task automatic send_sequence(input int len, input int pool);
		logic [7:0] base;
		base = 8'($urandom);
		for (int i = 0; i < len; i++)
			send_request(($urandom_range(9) == 0) ? 8'($urandom) :
				base + 8'($urandom_range(pool - 1)), i == len - 1);
	endtask

	initial begin
		int m, nf;
		repeat (9) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);
		// directed: reset settings, field extremes, each policy
		send_request(8'h00, 1'b0); send_request(8'hFF, 1'b0); send_request(8'h00, 1'b0);
		send_request(8'hAA, 1'b0); send_request(8'h55, 1'b0); send_request(8'hFF, 1'b1);
		drain();
		for (m = 0; m < 4; m++) begin
			write_reg(prs_pkg::CFG_MODE, m[4:0]);
			write_reg(prs_pkg::CFG_NFR, (m == 3) ? 5'd0 : 5'd2);
			send_request(8'd1, 1'b0); send_request(8'd2, 1'b0); send_request(8'd3, 1'b0);
			send_request(8'd1, 1'b0); send_request(8'd4, 1'b1);
			drain();
		end
		write_reg(prs_pkg::CFG_NFR, 5'd31);
		send_sequence(20, 24);
		drain();
		write_reg(prs_pkg::CFG_NFR, 5'd1);
		send_request(8'h7F, 1'b1);
		drain();
		// store overflow: 70 requests, the last six dropped
		write_reg(prs_pkg::CFG_MODE, 5'(prs_pkg::MODE_OPT));
		write_reg(prs_pkg::CFG_NFR, 5'd16);
		send_sequence(70, 30);
		drain();
		for (int ph = 0; ph < 3; ph++) begin
			send_idle = (ph == 0) ? 38 : (ph == 1) ? 50 : 0;
			recv_idle = (ph == 0) ? 50 : (ph == 1) ? 38 : 0;
			for (int s = 0; s < 8; s++) begin
				nf = (s == 0) ? 1 : (s == 1) ? 16 : $urandom_range(2, 8);
				write_reg(prs_pkg::CFG_MODE, 5'($urandom_range(3)));
				write_reg(prs_pkg::CFG_NFR, nf[4:0]);
				send_sequence($urandom_range(3, 21), $urandom_range(2, 20));
				drain();
			end
		end
		$display("Sent %0d requests, checked %0d result items over all policies",
			requests_sent, results_seen);
		$display("and frame counts from 1 to 16, including store overflow.");
		if (fail_count == 0)
			$display("** page_replacement_simulator_unit: PASSED **");
		else
			$display("** page_replacement_simulator_unit: FAILED **");
		$finish;
	end
endmodule

// ----- page_replacement_simulator_unit.f -----
hw/rtl/prs_pkg.sv
hw/rtl/prs_ram.sv
hw/rtl/prs_cell.sv
hw/rtl/page_replacement_simulator_unit.sv
tb/prs_checker.sv
tb/testbench.sv
